// File: design/rqwl_pkg.sv
package rqwl_pkg;

  // Field widths fixed by the result word
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 4;

  typedef enum logic [1:0] {
    OpPush   = 2'd0,
    OpPop    = 2'd1,
    OpLookup = 2'd2,
    OpDrain  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Per-cell write controls
  typedef struct packed {
    logic wr;
    logic clr;
  } cell_ctl_t;

endpackage

// File: design/rqwl_if.sv
interface rqwl_in_if #(
  parameter int unsigned RefW = 48
);
  logic            valid;
  logic            ready;
  logic [1:0]      opcode;
  logic [RefW-1:0] item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface rqwl_out_if #(
  parameter int unsigned RefW = 48
);
  logic                         valid;
  logic                         ready;
  logic [rqwl_pkg::StatusW-1:0] status;
  logic [RefW-1:0]              out_value;
  logic [rqwl_pkg::SlotW-1:0]   slot_index;
  logic                         found;
  logic [rqwl_pkg::CountW-1:0]  entry_count;
  logic                         is_last;

  modport source (output valid, output status, output out_value, output slot_index,
                  output found, output entry_count, output is_last, input ready);
  modport sink   (input valid, input status, input out_value, input slot_index,
                  input found, input entry_count, input is_last, output ready);
endinterface

// File: design/rqwl_cell.sv
module rqwl_cell #(
  parameter int unsigned RefW = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rqwl_pkg::cell_ctl_t ctl_i,
  input  logic [RefW-1:0]     wr_data_i,
  input  logic [RefW-1:0]     key_i,
  input  logic                hit_i,
  output logic                hit_o,
  output logic [RefW-1:0]     data_o
);

  logic [RefW-1:0] data_q;

  // Write on push, clear on pop; never both in one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (ctl_i.wr) begin
      data_q <= wr_data_i;
    end else if (ctl_i.clr) begin
      data_q <= '0;
    end
  end

  // Extend the match chain from the previous cell
  assign hit_o  = hit_i | (data_q == key_i);
  assign data_o = data_q;

endmodule

// File: design/ring_queue_with_lookup.sv
// Channel  Dir  Word                                 Handshake
// in_i     in   opcode, item_value                   valid/ready, taken when both high
// out_o    out  status, out_value, slot_index,       valid/ready, taken when both high
//               found, entry_count, is_last
//
// Push, pop and lookup need no sequencing: the slot cells compare against the key
// in parallel and the result lands in the output register on the accepting edge.
// A drain of N live entries holds the input until the last word loads: the accepting
// edge loads the cursor, then N words follow one per free cycle via the cell read mux.
// A stalled out_o holds the output register and, with it, the input side.
// Reset (rst_ni low, asynchronous) empties the queue and nulls every slot.
module ring_queue_with_lookup #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned REF_WIDTH = 48
) (
  input logic clk_i,
  input logic rst_ni,
  rqwl_in_if.sink    in_i,
  rqwl_out_if.source out_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  state_e            state_q;
  logic [PtrW-1:0]   head_q;
  logic [PtrW-1:0]   tail_q;
  logic [PtrW-1:0]   cur_q;     // drain cursor
  logic [PtrW-1:0]   rem_q;     // drain words still to load
  logic [PtrW-1:0]   dcount_q;  // entries held when the drain began

  // Output register
  logic                          out_valid_q;
  rqwl_pkg::status_e             status_q;
  logic [REF_WIDTH-1:0]          value_q;
  logic [rqwl_pkg::SlotW-1:0]    slot_q;
  logic                          found_q;
  logic [rqwl_pkg::CountW-1:0]   count_q;
  logic                          last_q;

  logic                          out_valid_d;
  rqwl_pkg::status_e             status_d;
  logic [REF_WIDTH-1:0]          value_d;
  logic [rqwl_pkg::SlotW-1:0]    slot_d;
  logic                          found_d;
  logic [rqwl_pkg::CountW-1:0]   count_d;
  logic                          last_d;

  // Cell chain
  rqwl_pkg::cell_ctl_t  ctl    [DEPTH];
  logic [REF_WIDTH-1:0] cell_q [DEPTH];
  logic                 hit    [DEPTH+1];

  rqwl_pkg::op_e        op;
  logic                 out_free;
  logic                 in_acc;
  logic [PtrW-1:0]      head_nxt;
  logic                 full;
  logic                 empty;
  logic [PtrW-1:0]      len;
  logic [PtrW-1:0]      rd_addr;
  logic [REF_WIDTH-1:0] rd_data;
  logic                 drain_step;

  assign op       = rqwl_pkg::op_e'(in_i.opcode);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;

  assign head_nxt = head_q + PtrW'(1);
  assign full     = (head_nxt == tail_q);
  assign empty    = (head_q == tail_q);
  assign len      = head_q - tail_q;

  // One read port: drain cursor while draining, tail otherwise
  assign rd_addr = (state_q == StDrain) ? cur_q : tail_q;
  assign rd_data = cell_q[rd_addr];

  assign drain_step = (state_q == StDrain) && out_free;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].wr  = in_acc && (op == rqwl_pkg::OpPush) && !full && (head_q == PtrW'(i));
      ctl[i].clr = in_acc && (op == rqwl_pkg::OpPop) && (tail_q == PtrW'(i));
    end

    rqwl_cell #(
      .RefW(REF_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl[i]),
      .wr_data_i(in_i.item_value),
      .key_i    (in_i.item_value),
      .hit_i    (hit[i]),
      .hit_o    (hit[i+1]),
      .data_o   (cell_q[i])
    );
  end

  // Next content of the output register; drop the word once taken
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    value_d     = value_q;
    slot_d      = slot_q;
    found_d     = found_q;
    count_d     = count_q;
    last_d      = last_q;
    if (in_acc) begin
      // Fields with no meaning for the operation read as zero; is_last reads as one
      status_d = rqwl_pkg::StOk;
      value_d  = '0;
      slot_d   = '0;
      found_d  = 1'b0;
      count_d  = '0;
      last_d   = 1'b1;
      unique case (op)
        rqwl_pkg::OpPush: begin
          out_valid_d = 1'b1;
          if (full) begin
            status_d = rqwl_pkg::StFull;
          end else begin
            slot_d = rqwl_pkg::SlotW'(head_nxt);
          end
        end
        rqwl_pkg::OpPop: begin
          // Read the tail slot even when empty
          out_valid_d = 1'b1;
          value_d     = rd_data;
          if (empty) begin
            status_d = rqwl_pkg::StEmpty;
          end
        end
        rqwl_pkg::OpLookup: begin
          out_valid_d = 1'b1;
          found_d     = hit[DEPTH];
        end
        rqwl_pkg::OpDrain: begin
          // Only an empty drain answers here; otherwise the cursor loads the words
          if (empty) begin
            out_valid_d = 1'b1;
            status_d    = rqwl_pkg::StEmpty;
          end
        end
        default: begin
          out_valid_d = 1'b1;
        end
      endcase
    end else if (drain_step) begin
      // Load one live entry a cycle while out_o is free, wrapping with the cursor
      out_valid_d = 1'b1;
      status_d    = rqwl_pkg::StOk;
      value_d     = rd_data;
      slot_d      = rqwl_pkg::SlotW'(cur_q);
      found_d     = 1'b0;
      count_d     = rqwl_pkg::CountW'(dcount_q);
      last_d      = (rem_q == PtrW'(1));
    end
  end

  // Sequencer, pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      cur_q       <= '0;
      rem_q       <= '0;
      dcount_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= rqwl_pkg::StOk;
      value_q     <= '0;
      slot_q      <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      value_q     <= value_d;
      slot_q      <= slot_d;
      found_q     <= found_d;
      count_q     <= count_d;
      last_q      <= last_d;

      if (in_acc) begin
        unique case (op)
          rqwl_pkg::OpPush: begin
            if (!full) begin
              head_q <= head_nxt;
            end
          end
          rqwl_pkg::OpPop: begin
            // Hold tail when empty
            if (!empty) begin
              tail_q <= tail_q + PtrW'(1);
            end
          end
          rqwl_pkg::OpLookup: ;
          rqwl_pkg::OpDrain: begin
            // Reset pointers at once; slot contents stay
            head_q <= '0;
            tail_q <= '0;
            if (!empty) begin
              state_q  <= StDrain;
              cur_q    <= tail_q;
              rem_q    <= len;
              dcount_q <= len;
            end
          end
          default: ;
        endcase
      end else if (drain_step) begin
        cur_q <= cur_q + PtrW'(1);
        rem_q <= rem_q - PtrW'(1);
        if (rem_q == PtrW'(1)) begin
          state_q <= StIdle;
        end
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.out_value   = value_q;
  assign out_o.slot_index  = slot_q;
  assign out_o.found       = found_q;
  assign out_o.entry_count = count_q;
  assign out_o.is_last     = last_q;

`ifndef SYNTH
  a_drain_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> (rem_q != '0))
    else $error("drain active with nothing left to emit");

  a_drain_clears_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == rqwl_pkg::OpDrain)) |=> ((head_q == '0) && (tail_q == '0)))
    else $error("pointers not reset after drain");

  a_drain_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && (rem_q == PtrW'(1))) |=> (out_valid_q && last_q && (state_q == StIdle)))
    else $error("final drain word not marked last");

  a_push_advances_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == rqwl_pkg::OpPush) && !full) |=> (head_q == $past(head_nxt)))
    else $error("head did not advance on push");
`endif

endmodule

// File: tb/rqwl_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the ring queue, keeps a shadow copy of the ring,
// and compares every result word with the oldest one it has worked out.
module rqwl_checker #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned REF_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     in_opcode_i,
  input  logic [REF_WIDTH-1:0]           in_item_value_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [rqwl_pkg::StatusW-1:0]   out_status_i,
  input  logic [REF_WIDTH-1:0]           out_value_i,
  input  logic [rqwl_pkg::SlotW-1:0]     out_slot_index_i,
  input  logic                           out_found_i,
  input  logic [rqwl_pkg::CountW-1:0]    out_entry_count_i,
  input  logic                           out_is_last_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  typedef logic [PtrW-1:0] ptr_t;

  typedef struct {
    rqwl_pkg::status_e            status;
    logic [REF_WIDTH-1:0]         value;
    logic [rqwl_pkg::SlotW-1:0]   slot;
    logic                         found;
    logic [rqwl_pkg::CountW-1:0]  count;
    logic                         is_last;
  } ring_word_t;

  logic [REF_WIDTH-1:0] shadow_cells [DEPTH];
  ptr_t                 shadow_head;
  ptr_t                 shadow_tail;
  ring_word_t           awaited_words [$];

  // Apply one accepted word to the shadow ring and queue the words it yields
  task automatic advance_shadow_ring(input rqwl_pkg::op_e op,
                                     input logic [REF_WIDTH-1:0] key);
    ptr_t       next_head;
    ptr_t       span;
    ptr_t       idx;
    ring_word_t w;
    logic       hit;
    int         k;
    w.status  = rqwl_pkg::StOk;
    w.value   = '0;
    w.slot    = '0;
    w.found   = 1'b0;
    w.count   = '0;
    w.is_last = 1'b1;
    case (op)
      rqwl_pkg::OpPush: begin
        next_head = shadow_head + 1'b1;
        if (next_head != shadow_tail) begin
          shadow_cells[shadow_head] = key;
          shadow_head = next_head;
          w.slot = rqwl_pkg::SlotW'(next_head);
        end else begin
          w.status = rqwl_pkg::StFull;
        end
        awaited_words.push_back(w);
      end
      rqwl_pkg::OpPop: begin
        // the tail cell is read and nulled even when the ring is empty
        w.value = shadow_cells[shadow_tail];
        shadow_cells[shadow_tail] = '0;
        if (shadow_head != shadow_tail) shadow_tail = shadow_tail + 1'b1;
        else w.status = rqwl_pkg::StEmpty;
        awaited_words.push_back(w);
      end
      rqwl_pkg::OpLookup: begin
        hit = 1'b0;
        foreach (shadow_cells[i]) if (shadow_cells[i] == key) hit = 1'b1;
        w.found = hit;
        awaited_words.push_back(w);
      end
      rqwl_pkg::OpDrain: begin
        span = shadow_head - shadow_tail;
        if (span == '0) begin
          w.status = rqwl_pkg::StEmpty;
          awaited_words.push_back(w);
        end else begin
          for (k = 0; k < int'(span); k++) begin
            idx       = shadow_tail + ptr_t'(k);
            w.value   = shadow_cells[idx];
            w.slot    = rqwl_pkg::SlotW'(idx);
            w.count   = rqwl_pkg::CountW'(span);
            w.is_last = (k == int'(span) - 1);
            awaited_words.push_back(w);
          end
        end
        // cells keep their contents, only the pointers go back to zero
        shadow_head = '0;
        shadow_tail = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_word_t want;
    if (!rst_ni) begin
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      shadow_head = '0;
      shadow_tail = '0;
      awaited_words.delete();
    end else begin
      // results are registered and never leave in the cycle their word is taken: compare first
      if (out_valid_i && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual value 0x%0h slot %0d",
                   $time, out_value_i, out_slot_index_i);
          fail_count_o++;
        end else begin
          want = awaited_words.pop_front();
          check_field("result status", 64'(want.status), 64'(out_status_i));
          check_field("out_value", 64'(want.value), 64'(out_value_i));
          check_field("slot_index", 64'(want.slot), 64'(out_slot_index_i));
          check_field("found", 64'(want.found), 64'(out_found_i));
          check_field("entry_count", 64'(want.count), 64'(out_entry_count_i));
          check_field("is_last", 64'(want.is_last), 64'(out_is_last_i));
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_shadow_ring(rqwl_pkg::op_e'(in_opcode_i), in_item_value_i);
      end
    end
    pending_o = awaited_words.size();
  end

endmodule

// File: tb/ring_queue_with_lookup_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the ring queue. The checker beside the block does
// all prediction and comparison; this module only drives words, idles the
// two sides and decides when the run is over.
module ring_queue_with_lookup_tb;

  localparam int unsigned Depth        = 16;
  localparam int unsigned RefW         = 48;
  localparam int unsigned RandomWords  = 450;
  localparam int unsigned IdlePercent  = 29;
  localparam int unsigned HoldCycles   = 80;    // long receiver hold-off
  localparam int unsigned StallLimit   = 2000;  // cycles with no word moving
  localparam int unsigned SettleCycles = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rqwl_in_if  #(.RefW(RefW)) in_ch ();
  rqwl_out_if #(.RefW(RefW)) out_ch ();

  int fail_count;
  int pending;
  int checked;

  // Idling switches and the hold-off hand-over between stimulus and receiver
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;
  int hold_requests = 0;
  int holds_served  = 0;

  int              op_tally [4];
  int              quiet_cycles = 0;
  logic [RefW-1:0] recent_refs [$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ring_queue_with_lookup #(
    .DEPTH    (Depth),
    .REF_WIDTH(RefW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  rqwl_checker #(
    .DEPTH    (Depth),
    .REF_WIDTH(RefW)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_opcode_i      (in_ch.opcode),
    .in_item_value_i  (in_ch.item_value),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_status_i     (out_ch.status),
    .out_value_i      (out_ch.out_value),
    .out_slot_index_i (out_ch.slot_index),
    .out_found_i      (out_ch.found),
    .out_entry_count_i(out_ch.entry_count),
    .out_is_last_i    (out_ch.is_last),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Receiver: drop ready at random, or hold it low for a long stretch when
  // the stimulus asks. The hold is counted here, in cycles, so the sender
  // keeps offering words and the block backs up into its input.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= !(snk_idle_on && $urandom_range(99) < IdlePercent);
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  // The longest legitimate silence is a receiver hold-off, well under the limit.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t ns: no word moved for %0d cycles, %0d results still awaited",
               $time, quiet_cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [RefW-1:0] random_ref();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[RefW-1:0];
  endfunction

  // Reference to push: mostly random, now and then null or all ones
  function automatic logic [RefW-1:0] fresh_ref();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return random_ref();
  endfunction

  // Lookup key: lean on recently pushed references so hits are common,
  // and try null often since free cells hold it
  function automatic logic [RefW-1:0] lookup_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && recent_refs.size() > 0) return recent_refs[$urandom_range(recent_refs.size() - 1)];
    if (r < 55) return '0;
    if (r < 60) return '1;
    return random_ref();
  endfunction

  // Offer one word from the falling edge and hold it until it is taken.
  // Idle cycles go in front of the word so that gaps fall anywhere.
  task automatic send_word(input rqwl_pkg::op_e op, input logic [RefW-1:0] value);
    @(negedge clk_i);
    while (src_idle_on && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= value;
    op_tally[op]++;
    if (op == rqwl_pkg::OpPush) begin
      recent_refs.push_back(value);
      if (recent_refs.size() > 32) void'(recent_refs.pop_front());
    end
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering and wait until every awaited result has come out
  task automatic wait_until_quiet();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [RefW-1:0] first_ref;
    int unsigned     mode;
    int unsigned     r;
    int unsigned     push_cut;
    int unsigned     pop_cut;
    int unsigned     look_cut;
    rqwl_pkg::op_e   op;

    in_ch.valid      = 1'b0;
    in_ch.opcode     = rqwl_pkg::OpPush;
    in_ch.item_value = '0;
    foreach (op_tally[i]) op_tally[i] = 0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-ring corner cases straight out of reset
    send_word(rqwl_pkg::OpPop, '1);         // pop on empty returns the null cell
    send_word(rqwl_pkg::OpDrain, '0);       // drain on empty: single word, empty status
    send_word(rqwl_pkg::OpLookup, '0);      // null key matches the free cells
    send_word(rqwl_pkg::OpLookup, '1);      // all-ones key misses

    // Move the pointers off zero so the later drain has to wrap
    send_word(rqwl_pkg::OpPush, '1);
    send_word(rqwl_pkg::OpPush, 48'h1);
    send_word(rqwl_pkg::OpPop, '0);
    send_word(rqwl_pkg::OpPop, '0);

    // Fill to the brim (one cell stays free), pushing a null on the way,
    // then one more push that must be refused
    first_ref = 48'hA5A5_5A5A_F00F;
    send_word(rqwl_pkg::OpPush, first_ref);
    for (int i = 1; i < Depth - 1; i++) begin
      send_word(rqwl_pkg::OpPush, (i == 7) ? '0 : random_ref());
    end
    send_word(rqwl_pkg::OpPush, '1);
    send_word(rqwl_pkg::OpLookup, first_ref);

    // Full drain with wrap, then a pop that finds the stale cell at slot zero
    send_word(rqwl_pkg::OpDrain, '0);
    send_word(rqwl_pkg::OpPop, '0);
    wait_until_quiet();

    // Random part: blocks of thirty words, each block leaning towards
    // filling, emptying, or an even mix so the ring visits every fill level
    mode = 0;
    for (int n = 0; n < RandomWords; n++) begin
      if (n % 30 == 0) mode = $urandom_range(2);
      if (n == 120 || n == 330) hold_requests++;
      if (n == 250) wait_until_quiet();
      // a long stretch with neither side idling
      src_idle_on = !(n >= 280 && n < 400);
      snk_idle_on = src_idle_on;

      case (mode)
        0: begin
          push_cut = 70; pop_cut = 80; look_cut = 94;
        end
        1: begin
          push_cut = 30; pop_cut = 75; look_cut = 90;
        end
        default: begin
          push_cut = 45; pop_cut = 70; look_cut = 91;
        end
      endcase
      r = $urandom_range(99);
      if (r < push_cut) op = rqwl_pkg::OpPush;
      else if (r < pop_cut) op = rqwl_pkg::OpPop;
      else if (r < look_cut) op = rqwl_pkg::OpLookup;
      else op = rqwl_pkg::OpDrain;

      // pop and drain ignore the value, so let it toggle freely
      if (op == rqwl_pkg::OpPush) send_word(op, fresh_ref());
      else if (op == rqwl_pkg::OpLookup) send_word(op, lookup_key());
      else send_word(op, random_ref());
    end

    wait_until_quiet();
    repeat (SettleCycles) @(negedge clk_i);

    $display("covered %0d input words: %0d push, %0d pop, %0d lookup, %0d drain",
             op_tally[rqwl_pkg::OpPush] + op_tally[rqwl_pkg::OpPop] +
             op_tally[rqwl_pkg::OpLookup] + op_tally[rqwl_pkg::OpDrain],
             op_tally[rqwl_pkg::OpPush], op_tally[rqwl_pkg::OpPop],
             op_tally[rqwl_pkg::OpLookup], op_tally[rqwl_pkg::OpDrain]);
    $display("compared %0d result words across %0d long receiver hold-offs and idle gaps",
             checked, holds_served);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: ring_queue_with_lookup.f
design/rqwl_pkg.sv
design/rqwl_if.sv
design/rqwl_cell.sv
design/ring_queue_with_lookup.sv
tb/rqwl_checker.sv
tb/ring_queue_with_lookup_tb.sv
